[hw/rtl/centered_fir_zero_padded_defines.svh]
// ----------------------------------------------------------------------------
// Centered FIR assertion macros
// Shared property shorthands for the centered FIR block.
// ----------------------------------------------------------------------------
`ifndef CENTERED_FIR_ZERO_PADDED_DEFINES_SVH
`define CENTERED_FIR_ZERO_PADDED_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFZP_IMPLIES(LBL, CLK, RSTN, ANT, CON) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CON)) \
    else $error("cfzp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CFZP_NEXT(LBL, CLK, RSTN, ANT, CON) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |=> (CON)) \
    else $error("cfzp: next-cycle check failed");

`endif

[hw/rtl/cfzp_pkg.sv]
// ----------------------------------------------------------------------------
// Centered FIR package
// Fixed widths, register codes and shared types of the centered FIR block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfzp_pkg;

  localparam int NUM_COEFS   = 5;
  localparam int COEF_BITS   = 16;
  localparam int OUT_BITS    = 35;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 3;
  // Holds the largest lag over the supported tap counts.
  localparam int CNT_W       = 2;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);

  typedef logic signed [COEF_BITS-1:0] coef_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_0 = 3'd0,
    REG_COEF_1 = 3'd1,
    REG_COEF_2 = 3'd2,
    REG_COEF_3 = 3'd3,
    REG_COEF_4 = 3'd4
  } cfg_reg_e;

  // Control part of one queued job.
  typedef struct packed {
    logic             last;
    logic [CNT_W-1:0] cnt;
  } job_ctl_t;

  // Back end status seen by the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } bk_sts_t;

endpackage

`default_nettype wire

[hw/rtl/centered_fir_zero_padded.sv]
// ----------------------------------------------------------------------------
// Centered FIR filter with zero padding
// Streaming centered convolution with five programmable tap weights.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Payload
//  in_      slave      in_tvalid/tready   tdata: sample; tlast: end of sequence
//  out_     master     out_tvalid/tready  tdata: filtered (35 b); tlast: final
//  cfg_     slave      cfg_valid/ready    cfg_index, cfg_data (tap weight)
//
//  An ordinary sample takes one step of the back end, so one item per clock
//  is sustained while the output is not stalled. A sample marked last takes
//  one back end step for each flushed window position of the expander.
//  From input to result an item passes the queue, the expander, the multiply
//  and the sum into the output register.
//  Reset is synchronous and clears delay line, count, queue and pipeline
//  valids at once; no clearing pass follows. Each pipeline stage moves when
//  the stage after it is empty or moving, and the two-entry queue lets input
//  acceptance go on while results wait at the output.
//
`timescale 1ns / 1ps
`default_nettype none

module centered_fir_zero_padded #(
  parameter int TAPS        = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Sample input.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic                                  in_tlast,   // end of sequence
  // Result output.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [cfzp_pkg::OUT_TDATA_W-1:0]      out_tdata,  // [34:0] filtered
  output logic                                  out_tlast,  // final result of sequence
  // Tap weight writes.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cfzp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cfzp_pkg::COEF_BITS-1:0]        cfg_data
);
  import cfzp_pkg::*;

  `include "centered_fir_zero_padded_defines.svh"

  localparam int JOB_W = TAPS * SAMPLE_BITS + $bits(job_ctl_t);

  coef_t               coef_r   [NUM_COEFS];
  coef_t               coef_nxt [NUM_COEFS];

  logic                f_valid;
  logic                f_ready;
  logic [JOB_W-1:0]    f_data;
  logic                q_valid;
  logic                q_ready;
  logic [JOB_W-1:0]    q_data;
  logic [OUT_BITS-1:0] sum;
  bk_sts_t             bk_sts;

  // Weight registers. Writes to indexes past the list are dropped; the
  // port never stalls.
  assign cfg_ready = 1'b1;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_valid) begin
      case (cfg_reg_e'(cfg_index))
        REG_COEF_0: coef_nxt[0] = cfg_data;
        REG_COEF_1: coef_nxt[1] = cfg_data;
        REG_COEF_2: coef_nxt[2] = cfg_data;
        REG_COEF_3: coef_nxt[3] = cfg_data;
        REG_COEF_4: coef_nxt[4] = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < NUM_COEFS; m++) begin
        coef_r[m] <= '0;
      end
    end else begin
      coef_r <= coef_nxt;
    end
  end

  // The front end owns the delay line and the per-sequence count, and hands
  // a complete window plus its count and last flag to the queue.
  cfzp_front #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_tvalid),
    .in_ready_o (in_tready),
    .sample_i   (in_tdata[SAMPLE_BITS-1:0]),
    .last_i     (in_tlast),
    .q_valid_o  (f_valid),
    .q_ready_i  (f_ready),
    .q_data_o   (f_data)
  );

  cfzp_fifo #(
    .WIDTH (JOB_W)
  ) u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_data),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  // The back end turns each job into zero or more window positions and
  // computes one full-precision sum per emitted position.
  cfzp_back #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .coef_i      (coef_r),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_sum_o   (sum),
    .out_last_o  (out_tlast),
    .sts_o       (bk_sts)
  );

  assign out_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, sum};

  // An accepted item is in the queue on the next cycle.
  `CFZP_NEXT(a_push_lands, clk, rst_n, in_tvalid && in_tready, q_valid)
  // An idle or finishing back end always takes a waiting job.
  `CFZP_IMPLIES(a_back_pops, clk, rst_n, q_valid && (!bk_sts.busy || bk_sts.done), q_ready)
  // Input only stalls when the queue holds work.
  `CFZP_IMPLIES(a_stall_full, clk, rst_n, !in_tready, q_valid)

endmodule

`default_nettype wire

[hw/rtl/cfzp_front.sv]
// ----------------------------------------------------------------------------
// Centered FIR front end
// Accepts samples, keeps the delay line and count, and forms one job per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfzp_front #(
  parameter int TAPS        = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   in_valid_i,
  output logic                                                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0]                                 sample_i,
  input  logic                                                   last_i,
  output logic                                                   q_valid_o,
  input  logic                                                   q_ready_i,
  output logic [TAPS*SAMPLE_BITS+$bits(cfzp_pkg::job_ctl_t)-1:0] q_data_o
);
  import cfzp_pkg::*;

  localparam int LAG   = TAPS - 1 - TAPS / 2;
  localparam int WIN_W = TAPS * SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0] dl_r   [TAPS-1];
  logic [SAMPLE_BITS-1:0] dl_nxt [TAPS-1];
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       cnt_nxt;
  logic                   accept;
  job_ctl_t               ctl;
  logic [WIN_W-1:0]       win;

  assign in_ready_o = q_ready_i;
  assign q_valid_o  = in_valid_i;
  assign accept     = in_valid_i && q_ready_i;

  // The window is the stored samples, oldest in the lowest slot, then the new one.
  always_comb begin
    for (int m = 0; m < TAPS - 1; m++) begin
      win[m*SAMPLE_BITS +: SAMPLE_BITS] = dl_r[m];
    end
    win[(TAPS-1)*SAMPLE_BITS +: SAMPLE_BITS] = sample_i;
    ctl.last = last_i;
    ctl.cnt  = cnt_r;
    q_data_o = {ctl, win};
  end

  always_comb begin
    dl_nxt  = dl_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (last_i) begin
        for (int m = 0; m < TAPS - 1; m++) begin
          dl_nxt[m] = '0;
        end
        cnt_nxt = '0;
      end else begin
        for (int m = 0; m < TAPS - 2; m++) begin
          dl_nxt[m] = dl_r[m+1];
        end
        dl_nxt[TAPS-2] = sample_i;
        if (cnt_r != CNT_W'(LAG)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < TAPS - 1; m++) begin
        dl_r[m] <= '0;
      end
      cnt_r <= '0;
    end else begin
      dl_r  <= dl_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cfzp_fifo.sv]
// ----------------------------------------------------------------------------
// Centered FIR job queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfzp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);
  import cfzp_pkg::*;

  logic [WIDTH-1:0]  mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r;
  logic [QPTR_W:0]   cnt_nxt;
  logic              push;
  logic              pop;

  assign in_ready_o  = (cnt_r != (QPTR_W + 1)'(QDEPTH));
  assign out_valid_o = (cnt_r != '0);
  assign out_data_o  = mem_r[rd_ptr_r];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cfzp_back.sv]
// ----------------------------------------------------------------------------
// Centered FIR back end
// Expands jobs into window positions, multiplies, sums and registers results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfzp_back #(
  parameter int TAPS        = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   q_valid_i,
  output logic                                                   q_ready_o,
  input  logic [TAPS*SAMPLE_BITS+$bits(cfzp_pkg::job_ctl_t)-1:0] q_data_i,
  input  cfzp_pkg::coef_t                                        coef_i [cfzp_pkg::NUM_COEFS],
  output logic                                                   out_valid_o,
  input  logic                                                   out_ready_i,
  output logic [cfzp_pkg::OUT_BITS-1:0]                          out_sum_o,
  output logic                                                   out_last_o,
  output cfzp_pkg::bk_sts_t                                      sts_o
);
  import cfzp_pkg::*;

  localparam int LAG    = TAPS - 1 - TAPS / 2;
  localparam int WIN_W  = TAPS * SAMPLE_BITS;
  localparam int CTL_W  = $bits(job_ctl_t);
  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W  = (PROD_W > OUT_BITS) ? PROD_W : OUT_BITS;
  // Taps beyond the register list carry zero weight and get no multiplier.
  localparam int NPROD  = (TAPS < NUM_COEFS) ? TAPS : NUM_COEFS;

  // Expander stage: one job, stepped once per window position.
  logic                          busy_r;
  logic                          busy_nxt;
  logic [CNT_W-1:0]              k_r;
  logic [CNT_W-1:0]              k_nxt;
  job_ctl_t                      ctl_r;
  logic signed [SAMPLE_BITS-1:0] win_r [TAPS];

  // Product stage and result stage.
  logic                          p_vld_r;
  logic                          p_fin_r;
  logic signed [PROD_W-1:0]      prod_r [NPROD];
  logic                          o_vld_r;
  logic                          o_fin_r;
  logic [OUT_BITS-1:0]           sum_r;

  logic                          o_adv;
  logic                          p_adv;
  logic                          step;
  logic [CNT_W:0]                pos;
  logic                          emit;
  logic [CNT_W-1:0]              k_end;
  logic                          final_step;
  logic                          done;
  logic                          load;
  logic signed [ACC_W-1:0]       acc;

  assign o_adv      = !o_vld_r || out_ready_i;
  assign p_adv      = !p_vld_r || o_adv;
  assign step       = busy_r && p_adv;
  assign pos        = {1'b0, k_r} + {1'b0, ctl_r.cnt};
  assign emit       = (pos >= (CNT_W + 1)'(LAG));
  assign k_end      = ctl_r.last ? CNT_W'(LAG) : '0;
  assign final_step = (k_r == k_end);
  assign done       = step && final_step;
  assign q_ready_o  = !busy_r || done;
  assign load       = q_valid_i && q_ready_o;

  assign sts_o.busy = busy_r;
  assign sts_o.done = done;

  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    if (done) begin
      busy_nxt = 1'b0;
    end else if (step) begin
      k_nxt = k_r + 1'b1;
    end
    if (load) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
  end

  // Flush positions move the window down and feed zeros behind it.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int m = 0; m < TAPS; m++) begin
        win_r[m] <= q_data_i[m*SAMPLE_BITS +: SAMPLE_BITS];
      end
      ctl_r <= q_data_i[WIN_W +: CTL_W];
    end else if (step && !final_step) begin
      for (int m = 0; m < TAPS - 1; m++) begin
        win_r[m] <= win_r[m+1];
      end
      win_r[TAPS-1] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (p_adv) begin
        p_vld_r <= step && emit;
      end
      if (o_adv) begin
        o_vld_r <= p_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_adv) begin
      p_fin_r <= ctl_r.last && final_step;
    end
  end

  for (genvar g = 0; g < NPROD; g++) begin : g_mul
    always_ff @(posedge clk) begin
      if (step) begin
        prod_r[g] <= PROD_W'(coef_i[g]) * PROD_W'(win_r[g]);
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int m = 0; m < NPROD; m++) begin
      acc = acc + ACC_W'(prod_r[m]);
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv) begin
      sum_r   <= acc[OUT_BITS-1:0];
      o_fin_r <= p_fin_r;
    end
  end

  assign out_valid_o = o_vld_r;
  assign out_sum_o   = sum_r;
  assign out_last_o  = o_fin_r;

endmodule

`default_nettype wire
